// ----- rtl/core/amm_pkg.sv -----
// Shared types, codes and constants for the affine matrix multiply core.
package amm_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int STORE_DEPTH = 12;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = PROD_W + 2;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] LAST_IDX  = 2'd3;
  localparam logic [1:0] LAST_COL  = 2'd2;
  localparam logic [ADDR_W-1:0] BIAS_BASE = ADDR_W'(9);

  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF_Q =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ELEM,
    ST_CONST
  } amm_state_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [1:0]               row;
    logic [1:0]               col;
    logic signed [DATA_W-1:0] value;
  } amm_in_t;

  typedef struct packed {
    logic [1:0]               out_row;
    logic [1:0]               out_col;
    logic signed [DATA_W-1:0] product;
    logic                     last;
  } amm_out_t;

  typedef struct packed {
    logic clr_acc;
    logic acc_en;
    logic bias_load;
    logic bias_sel;
  } amm_mac_ctl_t;

endpackage

// ----- rtl/core/amm_matrix_store.sv -----
// Twelve-entry element store, one write port, one read port, cleared at reset.
module amm_matrix_store
  import amm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem_r [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < STORE_DEPTH; n++) begin
        mem_r[n] <= '0;
      end
    end else if (wr_en && (wr_addr < ADDR_W'(STORE_DEPTH))) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = (rd_addr < ADDR_W'(STORE_DEPTH)) ? mem_r[rd_addr] : '0;

endmodule

// ----- rtl/core/amm_mac_unit.sv -----
// Shared multiply-accumulate unit with rounding, bias add and saturation.
module amm_mac_unit
  import amm_pkg::*;
(
  input  logic                     clk,
  input  amm_mac_ctl_t             ctl,
  input  logic signed [DATA_W-1:0] rd_a,
  input  logic signed [DATA_W-1:0] rd_b,
  output logic signed [DATA_W-1:0] result
);

  logic signed [DATA_W-1:0] op_a_r, op_b_r, bias_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, rnd_r;
  logic signed [ACC_W-1:0]  prod_ext, sum_w;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // operand -> product -> accumulate, one register per step
  always_ff @(posedge clk) begin
    op_a_r <= rd_a;
    op_b_r <= rd_b;
    prod_r <= op_a_r * op_b_r;
    if (ctl.clr_acc) begin
      acc_r <= prod_ext;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + prod_ext;
    end
    if (ctl.bias_load) begin
      bias_r <= ctl.bias_sel ? rd_b : '0;
    end
    // round to nearest, ties up
    rnd_r <= (acc_r + HALF_Q) >>> FRAC_BITS;
  end

  assign sum_w = rnd_r + {{(ACC_W-DATA_W){bias_r[DATA_W-1]}}, bias_r};

  always_comb begin
    if (sum_w > SAT_MAX) begin
      result = SAT_MAX[DATA_W-1:0];
    end else if (sum_w < SAT_MIN) begin
      result = SAT_MIN[DATA_W-1:0];
    end else begin
      result = sum_w[DATA_W-1:0];
    end
  end

endmodule

// ----- rtl/core/affine_matrix_multiply_core.sv -----
// Top level of the affine 4x4 matrix multiply core: sequencer, stores, output register.
//
// Load requests (kind 0 for A, 1 for B) write one Q16.16 element of columns 0..2
// into a 12-entry store; a load to column 3 and kind 3 are dropped. A compute
// request (kind 2) streams the 16 elements of A*B in row-major order, last
// flagged on row 3 column 3. Each element of columns 0..2 runs through one
// shared 32x32 multiplier: three products are issued on consecutive cycles,
// accumulated exactly, rounded to nearest (ties up), row 3 adds B[3][j], and
// the sum saturates to 32 bits. Operands, product, accumulator and rounded sum
// are each registered before the result is loaded into the output register;
// the constant column 3 follows the three computed elements of each row. An
// output stall holds the sequencer until the output register is free. in_stall
// is high throughout a compute, so no request is taken until it ends. Both
// stores come out of reset all zero.
module affine_matrix_multiply_core
  import amm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  amm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output amm_out_t out_data
);

  localparam logic [2:0] STEP_BIAS = 3'd3;
  localparam logic [2:0] STEP_OUT  = 3'd6;

  amm_state_t state_r, state_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt;
  logic [2:0] step_r, step_nxt;

  logic                     out_valid_r, out_valid_nxt;
  amm_out_t                 out_data_r, out_item_nxt;
  logic                     out_free, out_load;

  logic                     wr_a, wr_b;
  logic [ADDR_W-1:0]        wr_addr, a_addr, b_addr;
  logic signed [DATA_W-1:0] rd_a, rd_b, mac_result;
  amm_mac_ctl_t             mac_ctl;

  assign out_free = !out_valid_r || !out_stall;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_data.kind == KIND_COMPUTE)) begin
          state_nxt = ST_ELEM;
          i_nxt     = '0;
          j_nxt     = '0;
          step_nxt  = '0;
        end
      end
      ST_ELEM: begin
        if (step_r != STEP_OUT) begin
          step_nxt = step_r + 3'd1;
        end else if (out_free) begin
          j_nxt    = j_r + 2'd1;
          step_nxt = '0;
          if (j_r == LAST_COL) begin
            state_nxt = ST_CONST;
          end
        end
      end
      ST_CONST: begin
        if (out_free) begin
          if (i_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ELEM;
            i_nxt     = i_r + 2'd1;
            j_nxt     = '0;
            step_nxt  = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_stall     = 1'b1;
    wr_a         = 1'b0;
    wr_b         = 1'b0;
    wr_addr      = ({2'b00, in_data.row} << 1) + {2'b00, in_data.row} + {2'b00, in_data.col};
    // A[i][k], then B[k][j]; B[3][j] at the bias step
    a_addr       = ({2'b00, i_r} << 1) + {2'b00, i_r} + {2'b00, step_r[1:0]};
    b_addr       = ({2'b00, step_r[1:0]} << 1) + {2'b00, step_r[1:0]} + {2'b00, j_r};
    mac_ctl      = '0;
    out_load     = 1'b0;
    out_item_nxt.out_row = i_r;
    out_item_nxt.out_col = j_r;
    out_item_nxt.product = mac_result;
    out_item_nxt.last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_data.col != 2'd3)) begin
          case (in_data.kind)
            KIND_LOAD_A: wr_a = 1'b1;
            KIND_LOAD_B: wr_b = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ELEM: begin
        if (step_r >= STEP_BIAS) begin
          b_addr = BIAS_BASE + {2'b00, j_r};
        end
        mac_ctl.clr_acc   = (step_r == 3'd2);
        mac_ctl.acc_en    = (step_r == 3'd3) || (step_r == 3'd4);
        mac_ctl.bias_load = (step_r == STEP_BIAS);
        mac_ctl.bias_sel  = (i_r == LAST_IDX);
        out_load          = (step_r == STEP_OUT) && out_free;
      end
      ST_CONST: begin
        out_item_nxt.product = (i_r == LAST_IDX) ? ONE_Q : '0;
        out_item_nxt.last    = (i_r == LAST_IDX);
        out_load             = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- datapath ----------------
  amm_matrix_store u_store_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (a_addr),
    .rd_data (rd_a)
  );

  amm_matrix_store u_store_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (b_addr),
    .rd_data (rd_b)
  );

  amm_mac_unit u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .rd_a   (rd_a),
    .rd_b   (rd_b),
    .result (mac_result)
  );

`ifndef SYNTH
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ELEM) |-> (step_r <= STEP_OUT))
    else $error("step counter past output step");

  a_elem_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ELEM) |-> (j_r != 2'd3))
    else $error("computed element in column 3");

  a_const_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONST) |-> (j_r == 2'd3))
    else $error("constant column emitted off column 3");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_item_nxt.last) |=> (state_r == ST_IDLE))
    else $error("sequencer busy after last element");
`endif

endmodule

// ----- tb/affine_matrix_multiply_core_test.sv -----
// Self-checking testbench for the affine 4x4 matrix multiply core.
`timescale 1ns / 1ps

module affine_matrix_multiply_core_test;
  import amm_pkg::*;

  // Kind 3 is undefined and dropped; a load aimed at column 3 is dropped too,
  // since that column is implied by the affine form.
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [1:0] COL_IMPLIED  = 2'd3;
  localparam int         RANDOM_ITEMS = 75;

  typedef struct {
    amm_in_t req;
    int      gap;    // idle cycles before this request is offered
    bit      drain;  // hold it until every expected product has come back
  } pending_req_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  amm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  amm_out_t out_data;

  pending_req_t pending_reqs[$];
  amm_out_t     product_q[$];

  // Shadow copies of the two element stores, index row*3+col.
  logic signed [DATA_W-1:0] a_elems[STORE_DEPTH];
  logic signed [DATA_W-1:0] b_elems[STORE_DEPTH];

  int       fail_count = 0;
  bit       drv_busy;
  int       drv_wait   = 0;
  int       stall_left = 0;
  bit       calm       = 1'b0;
  amm_out_t mon_exp;

  affine_matrix_multiply_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // One product element of columns 0..2: exact three-term dot product,
  // rounded once to nearest with ties up, plus the row 3 translation term,
  // then clamped to 32 bits.
  function automatic logic signed [DATA_W-1:0] dot_element(int i, int j);
    logic signed [69:0] acc;
    longint             term;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      term = longint'(a_elems[i*3+k]) * longint'(b_elems[k*3+j]);
      acc  = acc + term;
    end
    acc = (acc + (70'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (i == LAST_IDX) acc = acc + b_elems[BIAS_BASE + j];
    if (acc > SAT_MAX) return SAT_MAX[DATA_W-1:0];
    if (acc < SAT_MIN) return SAT_MIN[DATA_W-1:0];
    return acc[DATA_W-1:0];
  endfunction

  // Apply one accepted request to the shadow stores and queue its products.
  function automatic void model_request(amm_in_t r);
    amm_out_t e;
    case (r.kind)
      KIND_LOAD_A: if (r.col != COL_IMPLIED) a_elems[r.row*3 + r.col] = r.value;
      KIND_LOAD_B: if (r.col != COL_IMPLIED) b_elems[r.row*3 + r.col] = r.value;
      KIND_COMPUTE: begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            e.out_row = i[1:0];
            e.out_col = j[1:0];
            if (j < 3) e.product = dot_element(i, j);
            else e.product = (i == LAST_IDX) ? ONE_Q : '0;
            e.last = (i == LAST_IDX) && (j == LAST_IDX);
            product_q.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic int req_gap(bit burst);
    if (burst || $urandom_range(0, 2) == 0) return 0;
    return pick_gap();
  endfunction

  // Element values: extremes, plus or minus one, small Q16.16 numbers and raw noise.
  function automatic logic signed [DATA_W-1:0] rand_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh8000_0000;
      3:       return r[0] ? ONE_Q : -ONE_Q;
      4, 5:    return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  task automatic queue_req(logic [1:0] kind, logic [1:0] row, logic [1:0] col,
                           logic signed [DATA_W-1:0] value, int gap, bit drain);
    pending_req_t p;
    p.req.kind  = kind;
    p.req.row   = row;
    p.req.col   = col;
    p.req.value = value;
    p.gap       = gap;
    p.drain     = drain;
    pending_reqs.push_back(p);
  endtask

  task automatic check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  // Request driver. A request stays put while stalled; the next one is only
  // offered after its gap, and a draining one waits for the product queue
  // to empty. in_valid gets exactly one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_wait = 0;
    end else begin
      drv_busy = in_valid;
      if (in_valid && !in_stall) begin
        model_request(in_data);
        drv_busy = 1'b0;
      end
      if (!drv_busy && pending_reqs.size() != 0) begin
        if (drv_wait < pending_reqs[0].gap) begin
          drv_wait++;
        end else if (!(pending_reqs[0].drain && product_q.size() != 0)) begin
          in_data <= pending_reqs[0].req;
          drv_busy = 1'b1;
          drv_wait = 0;
          void'(pending_reqs.pop_front());
        end
      end
      in_valid <= drv_busy;
    end
  end

  // Output backpressure: random stall bursts, with calm stretches where the
  // receiver never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 99) < 2) calm = ~calm;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        out_stall <= 1'b1;
        stall_left = pick_gap() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: every accepted product is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (product_q.size() == 0) begin
        $error("unexpected product: row %0d col %0d value %0d last %0d",
               out_data.out_row, out_data.out_col, out_data.product, out_data.last);
        fail_count++;
      end else begin
        mon_exp = product_q.pop_front();
        check_field("out_row", mon_exp.out_row, out_data.out_row);
        check_field("out_col", mon_exp.out_col, out_data.out_col);
        check_field("product", longint'(mon_exp.product), longint'(out_data.product));
        check_field("last", mon_exp.last, out_data.last);
      end
    end
  end

  initial begin
    int  n_items;
    int  n_loads;
    bit  burst;
    logic [1:0] kind;
    logic [1:0] col;

    for (int n = 0; n < STORE_DEPTH; n++) begin
      a_elems[n] = '0;
      b_elems[n] = '0;
    end

    // Directed part. Product of cleared stores: only the 1.0 corner is set.
    queue_req(KIND_COMPUTE, 2'd0, 2'd0, '0, 0, 1'b0);
    // Three most-negative terms per side: sum far above max, clamps high.
    for (int k = 0; k < 3; k++) begin
      queue_req(KIND_LOAD_A, 2'd0, k[1:0], 32'sh8000_0000, 0, 1'b0);
      queue_req(KIND_LOAD_B, k[1:0], 2'd0, 32'sh8000_0000, 0, 1'b0);
    end
    // Most negative times most positive: clamps low in column 1.
    for (int k = 0; k < 3; k++)
      queue_req(KIND_LOAD_B, k[1:0], 2'd1, 32'sh7fff_ffff, 1, 1'b0);
    // Exact half ties: +0.5 lsb rounds up, -0.5 lsb rounds to zero; row 3
    // then adds a maximal translation and clamps.
    queue_req(KIND_LOAD_A, 2'd3, 2'd0, 32'sd1, 0, 1'b0);
    queue_req(KIND_LOAD_B, 2'd0, 2'd2, 32'sh0000_8000, 0, 1'b0);
    queue_req(KIND_LOAD_B, 2'd3, 2'd2, 32'sh7fff_ffff, 0, 1'b0);
    queue_req(KIND_LOAD_A, 2'd1, 2'd0, -32'sd1, 2, 1'b0);
    queue_req(KIND_LOAD_B, 2'd3, 2'd0, 32'sh8000_0000, 0, 1'b0);
    // Dropped requests: column 3 loads and the unused kind.
    queue_req(KIND_LOAD_A, 2'd2, COL_IMPLIED, 32'sh5a5a_a5a5, 0, 1'b0);
    queue_req(KIND_LOAD_B, 2'd1, COL_IMPLIED, 32'shffff_ffff, 0, 1'b0);
    queue_req(KIND_UNUSED, 2'd3, 2'd3, 32'sh7fff_ffff, 0, 1'b0);
    // Compute with junk in the ignored fields, after a full drain.
    queue_req(KIND_COMPUTE, 2'd3, 2'd3, 32'shffff_ffff, 0, 1'b1);

    // Random part: load bursts followed by a compute, plus some noise.
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      burst   = ($urandom_range(0, 3) == 0);
      n_loads = $urandom_range(1, 12);
      for (int n = 0; n < n_loads; n++) begin
        kind = 2'($urandom_range(0, 1));
        col  = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) kind = KIND_UNUSED;
          else col = COL_IMPLIED;
        end else begin
          n_items++;
        end
        queue_req(kind, 2'($urandom_range(0, 3)), col, rand_value(), req_gap(burst), 1'b0);
      end
      queue_req(KIND_COMPUTE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom(),
                req_gap(burst), $urandom_range(0, 7) == 0);
      n_items++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (product_q.size() != 0) @(posedge clk);
    // Let any stray product show up before the verdict.
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
